### sv/pse_pkg.sv
// pse_pkg: shared types, codes and defaults for the postfix stack evaluator
// no dependencies; used by the interfaces, the stack cell, the alu and the top level
`default_nettype none

package pse_pkg;

   // fixed widths of the token and result words
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 3;

   // parameter defaults
   localparam int STACK_DEPTH_DEF = 64;
   localparam int FRAC_BITS_DEF   = 16;

   // token kinds
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPLY = 2'd1;
   localparam logic [OP_W-1:0] OP_END   = 2'd2;

   // operator characters
   localparam logic [CHAR_W-1:0] CHAR_ADD = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SUB = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_MUL = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_DIV = 8'h2F;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADOP   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVER    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_LEFT    = 3'd5;

   // saturation limits
   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   // what a stack cell loads
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PUSH = 2'd1,
      CELL_POP  = 2'd2
   } cell_mode_type;

   // arithmetic operation
   typedef enum logic [1:0] {
      AOP_ADD = 2'd0,
      AOP_SUB = 2'd1,
      AOP_MUL = 2'd2,
      AOP_DIV = 2'd3
   } aop_type;

   // request from the control to the alu
   typedef struct packed {
      logic                     start;
      aop_type                  aop;
      logic signed [DATA_W-1:0] lhs;
      logic signed [DATA_W-1:0] rhs;
   } alu_req_type;

   // answer from the alu
   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] value;
   } alu_rsp_type;

endpackage

`default_nettype wire

### sv/pse_if.sv
// pse_req_if / pse_rsp_if: valid/ready channels for token words and result words
// depends on pse_pkg for field widths
`default_nettype none

interface pse_req_if import pse_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [DATA_W-1:0] value;
   logic [CHAR_W-1:0]        operator_char;

   modport source (output valid, output op, output value, output operator_char,
                   input ready);
   modport sink   (input valid, input op, input value, input operator_char,
                   output ready);
endinterface

interface pse_rsp_if import pse_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] result_value;
   logic                     done_res;

   modport source (output valid, output status, output result_value, output done_res,
                   input ready);
   modport sink   (input valid, input status, input result_value, input done_res,
                   output ready);
endinterface

`default_nettype wire

### sv/pse_cell.sv
// pse_cell: one entry of the shifting operand stack
// depends on pse_pkg; loads from its upper neighbor on push, its lower one on pop
`default_nettype none

module pse_cell import pse_pkg::*; (
   input  wire                      clock,
   input  cell_mode_type            mode,
   input  wire signed [DATA_W-1:0]  from_prev,
   input  wire signed [DATA_W-1:0]  from_next,
   output logic signed [DATA_W-1:0] value
);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // neighbor select
   always_comb begin
      case (mode)
         CELL_PUSH: value_in = from_prev;
         CELL_POP:  value_in = from_next;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

### sv/pse_alu.sv
// pse_alu: saturating fixed point add, subtract, multiply and iterative divide
// depends on pse_pkg; divide runs one quotient bit per cycle
`default_nettype none

module pse_alu import pse_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   localparam int DW  = DATA_W + FRAC_BITS;
   localparam int CNT_W = $clog2(DW + 1);

   typedef enum logic [3:0] {
      A_IDLE = 4'b0001,
      A_MUL  = 4'b0010,
      A_DIV  = 4'b0100,
      A_FIN  = 4'b1000
   } alu_state_type;

   alu_state_type            state_ff, state_in;
   aop_type                  aop_ff, aop_in;
   logic                     done_ff, done_in;
   logic signed [DATA_W-1:0] result_ff, result_in;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic [DW-1:0]            quo_ff, quo_in;
   logic [DATA_W:0]          rem_ff, rem_in;
   logic [DATA_W-1:0]        dvs_ff, dvs_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic signed [DATA_W:0]     sum;
   logic signed [2*DATA_W-1:0] shifted;
   logic [DATA_W-1:0]          lhs_mag;
   logic [DATA_W-1:0]          rhs_mag;
   logic [DATA_W:0]            rem_sh;
   logic [DW-1:0]              lim_pos;

   assign lim_pos = DW'(SAT_MAX);

   always_comb begin
      state_in  = state_ff;
      aop_in    = aop_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      prod_in   = prod_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;

      // add or subtract with 33-bit result
      if (req.aop == AOP_SUB) begin
         sum = {req.lhs[DATA_W-1], req.lhs} - {req.rhs[DATA_W-1], req.rhs};
      end else begin
         sum = {req.lhs[DATA_W-1], req.lhs} + {req.rhs[DATA_W-1], req.rhs};
      end
      lhs_mag = req.lhs[DATA_W-1] ? DATA_W'(-req.lhs) : DATA_W'(req.lhs);
      rhs_mag = req.rhs[DATA_W-1] ? DATA_W'(-req.rhs) : DATA_W'(req.rhs);

      // restoring divide step
      rem_sh = {rem_ff[DATA_W-1:0], quo_ff[DW-1]};

      // product scaled back, floor by arithmetic shift
      shifted = prod_ff >>> FRAC_BITS;

      case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               aop_in = req.aop;
               case (req.aop)
                  AOP_MUL: begin
                     prod_in  = req.lhs * req.rhs;
                     state_in = A_MUL;
                  end
                  AOP_DIV: begin
                     quo_in   = DW'(lhs_mag) << FRAC_BITS;
                     rem_in   = '0;
                     dvs_in   = rhs_mag;
                     neg_in   = req.lhs[DATA_W-1] ^ req.rhs[DATA_W-1];
                     cnt_in   = CNT_W'(DW);
                     state_in = A_DIV;
                  end
                  default: begin
                     // saturate on sign disagreement of the two top bits
                     if (sum[DATA_W] != sum[DATA_W-1]) begin
                        result_in = sum[DATA_W] ? SAT_MIN : SAT_MAX;
                     end else begin
                        result_in = sum[DATA_W-1:0];
                     end
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         A_MUL: begin
            state_in = A_FIN;
         end
         A_DIV: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = rem_sh - {1'b0, dvs_ff};
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = A_FIN;
            end
         end
         A_FIN: begin
            if (aop_ff == AOP_MUL) begin
               if (shifted > 64'(SAT_MAX)) begin
                  result_in = SAT_MAX;
               end else if (shifted < 64'(SAT_MIN)) begin
                  result_in = SAT_MIN;
               end else begin
                  result_in = shifted[DATA_W-1:0];
               end
            end else if (neg_ff) begin
               if (quo_ff > lim_pos + DW'(1)) begin
                  result_in = SAT_MIN;
               end else begin
                  result_in = DATA_W'(-quo_ff);
               end
            end else begin
               if (quo_ff > lim_pos) begin
                  result_in = SAT_MAX;
               end else begin
                  result_in = quo_ff[DATA_W-1:0];
               end
            end
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      aop_ff    <= aop_in;
      result_ff <= result_in;
      prod_ff   <= prod_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = result_ff;

endmodule

`default_nettype wire

### sv/postfix_stack_evaluator.sv
// postfix_stack_evaluator: postfix evaluation over a row of shifting stack cells
// depends on pse_pkg, pse_if, pse_cell and pse_alu
//
// Usage: tokens arrive as words on req_bus (op, value, operator_char) and every
// token gives exactly one result word on rsp_bus (status, result_value, done_res).
// A word moves on a rising clock edge where valid and ready are both high.
// The operand stack is a row of STACK_DEPTH cells; the top is cell 0, a push
// shifts every cell down by one and an operator shifts them up by one with the
// new value entering cell 0, so the two operands always sit in cells 0 and 1.
// One token is worked on at a time. Push, end, ignored kinds and every error
// are settled without the alu; add, subtract, multiply and divide pass through
// the alu (multiply: registered 32x32 product, then shift and saturate; divide:
// the one-bit-per-cycle restoring divider), and the result word is registered.
// The result register frees the input side: the next token is accepted while a
// result still waits, and that token's own result waits until rsp_bus.ready.
// Synchronous reset empties the stack and drops any pending result; the cell
// contents are not cleared since only entries below the count are ever read.
`default_nettype none

module postfix_stack_evaluator import pse_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire clock,
   input  wire reset,
   pse_req_if.sink   req_bus,
   pse_rsp_if.source rsp_bus
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_ALU  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_PUSH  = 2'd1,
      ACT_APPLY = 2'd2,
      ACT_CLEAR = 2'd3
   } act_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [OP_W-1:0]          tok_op_ff, tok_op_in;
   logic [CHAR_W-1:0]        tok_char_ff, tok_char_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   act_type                  pend_act_ff, pend_act_in;
   logic [STATUS_W-1:0]      pend_status_ff, pend_status_in;
   logic signed [DATA_W-1:0] pend_value_ff, pend_value_in;
   logic                     pend_done_ff, pend_done_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic signed [DATA_W-1:0] stack_val [STACK_DEPTH];
   cell_mode_type            mode_top;
   cell_mode_type            mode_rest;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   // decode of the token in hand
   act_type             dec_act;
   logic [STATUS_W-1:0] dec_status;
   logic signed [DATA_W-1:0] dec_value;
   logic                dec_done;
   logic                dec_alu;
   logic                char_ok;
   aop_type             dec_aop;

   // commit of the pending action
   logic    rsp_free;
   logic    commit;
   act_type commit_act;

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // operator character to alu op
   always_comb begin
      char_ok = 1'b1;
      case (tok_char_ff)
         CHAR_ADD: dec_aop = AOP_ADD;
         CHAR_SUB: dec_aop = AOP_SUB;
         CHAR_MUL: dec_aop = AOP_MUL;
         CHAR_DIV: dec_aop = AOP_DIV;
         default: begin
            dec_aop = AOP_ADD;
            char_ok = 1'b0;
         end
      endcase
   end

   // token decode against the stack count and top cells
   always_comb begin
      dec_act    = ACT_NONE;
      dec_status = ST_OK;
      dec_value  = '0;
      dec_done   = 1'b0;
      dec_alu    = 1'b0;
      case (tok_op_ff)
         OP_PUSH: begin
            if (count_ff == CW'(STACK_DEPTH)) begin
               dec_act    = ACT_CLEAR;
               dec_status = ST_OVER;
               dec_done   = 1'b1;
            end else begin
               dec_act = ACT_PUSH;
            end
         end
         OP_APPLY: begin
            if (count_ff < CW'(2)) begin
               dec_act    = ACT_CLEAR;
               dec_status = ST_UNDER;
               dec_done   = 1'b1;
            end else if (!char_ok) begin
               dec_act    = ACT_CLEAR;
               dec_status = ST_BADOP;
               dec_done   = 1'b1;
            end else if (dec_aop == AOP_DIV && stack_val[0] == '0) begin
               dec_act    = ACT_CLEAR;
               dec_status = ST_DIVZERO;
               dec_done   = 1'b1;
            end else begin
               dec_act = ACT_APPLY;
               dec_alu = 1'b1;
            end
         end
         OP_END: begin
            dec_act  = ACT_CLEAR;
            dec_done = 1'b1;
            if (count_ff == '0) begin
               dec_status = ST_UNDER;
            end else if (count_ff != CW'(1)) begin
               dec_status = ST_LEFT;
            end else begin
               dec_value = stack_val[0];
            end
         end
         default: begin
            dec_act = ACT_NONE;
         end
      endcase
   end

   assign alu_req.start = (state_ff == S_EXEC) && dec_alu;
   assign alu_req.aop   = dec_aop;
   assign alu_req.lhs   = stack_val[1];
   assign alu_req.rhs   = stack_val[0];

   assign commit = rsp_free && (((state_ff == S_EXEC) && !dec_alu) || (state_ff == S_FIN));
   assign commit_act = (state_ff == S_EXEC) ? dec_act : pend_act_ff;

   // sequencer, stack count and result register
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      tok_op_in      = tok_op_ff;
      tok_char_in    = tok_char_ff;
      data_in        = data_ff;
      pend_act_in    = pend_act_ff;
      pend_status_in = pend_status_ff;
      pend_value_in  = pend_value_ff;
      pend_done_in   = pend_done_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_done_in    = rsp_done_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               tok_op_in   = req_bus.op;
               tok_char_in = req_bus.operator_char;
               data_in     = req_bus.value;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            pend_act_in    = dec_act;
            pend_status_in = dec_status;
            pend_value_in  = dec_value;
            pend_done_in   = dec_done;
            if (dec_alu) begin
               state_in = S_ALU;
            end else if (commit) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_FIN;
            end
         end
         S_ALU: begin
            if (alu_rsp.done) begin
               data_in  = alu_rsp.value;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (commit) begin
         rsp_valid_in = 1'b1;
         if (state_ff == S_EXEC) begin
            rsp_status_in = dec_status;
            rsp_value_in  = dec_value;
            rsp_done_in   = dec_done;
         end else begin
            rsp_status_in = pend_status_ff;
            rsp_value_in  = pend_value_ff;
            rsp_done_in   = pend_done_ff;
         end
         case (commit_act)
            ACT_PUSH:  count_in = count_ff + CW'(1);
            ACT_APPLY: count_in = count_ff - CW'(1);
            ACT_CLEAR: count_in = '0;
            default:   count_in = count_ff;
         endcase
      end
   end

   // cell shift control
   always_comb begin
      mode_top  = CELL_HOLD;
      mode_rest = CELL_HOLD;
      if (commit) begin
         case (commit_act)
            ACT_PUSH: begin
               mode_top  = CELL_PUSH;
               mode_rest = CELL_PUSH;
            end
            ACT_APPLY: begin
               mode_top  = CELL_PUSH;
               mode_rest = CELL_POP;
            end
            default: begin
               mode_top  = CELL_HOLD;
               mode_rest = CELL_HOLD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tok_op_ff      <= tok_op_in;
      tok_char_ff    <= tok_char_in;
      data_ff        <= data_in;
      pend_act_ff    <= pend_act_in;
      pend_status_ff <= pend_status_in;
      pend_value_ff  <= pend_value_in;
      pend_done_ff   <= pend_done_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_done_ff    <= rsp_done_in;
   end

   // row of stack cells, cell 0 is the top
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] prev_val;
      logic signed [DATA_W-1:0] next_val;
      cell_mode_type            cell_mode;
      if (i == 0) begin : g_top
         assign prev_val  = data_ff;
         assign cell_mode = mode_top;
      end else begin : g_mid
         assign prev_val  = stack_val[i-1];
         assign cell_mode = mode_rest;
      end
      if (i == STACK_DEPTH - 1) begin : g_end
         assign next_val = '0;
      end else begin : g_inner
         assign next_val = stack_val[i+1];
      end
      pse_cell u_cell (
         .clock     (clock),
         .mode      (cell_mode),
         .from_prev (prev_val),
         .from_next (next_val),
         .value     (stack_val[i])
      );
   end

   pse_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.result_value = rsp_value_ff;
   assign rsp_bus.done_res     = rsp_done_ff;

endmodule

`default_nettype wire

### sv/pse_checker.sv
// pse_checker: port-level checks on the postfix stack evaluator, bound to the top level
// depends on pse_pkg and postfix_stack_evaluator
`default_nettype none

module pse_checker import pse_pkg::*; (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_valid,
   input wire                      req_ready,
   input wire                      rsp_valid,
   input wire                      rsp_ready,
   input wire [STATUS_W-1:0]       rsp_status,
   input wire signed [DATA_W-1:0]  rsp_result_value,
   input wire                      rsp_done_res
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_value) && $stable(rsp_done_res))
      else $error("result word changed while stalled");

   // reset drops any pending result
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one token at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("token taken while another is in work");

   // every error closes the expression
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_done_res && rsp_result_value == '0)
      else $error("error result not closing or carrying a value");

   // a value appears only on a successful end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_value != '0 |-> rsp_done_res && rsp_status == ST_OK)
      else $error("value on a result that is not a successful end");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_result_value (rsp_bus.result_value),
   .rsp_done_res     (rsp_bus.done_res)
);

`default_nettype wire

### dv/postfix_stack_evaluator_test.sv
`timescale 1ns / 1ps
// postfix_stack_evaluator_test: token stream stimulus, a shadow evaluator and result checks
// depends on pse_pkg, pse_if and postfix_stack_evaluator

module postfix_stack_evaluator_test;
   import pse_pkg::*;

   localparam int  ITEM_TARGET  = 1850;
   localparam int  STEADY_TAIL  = 150;
   localparam int  CYCLE_LIMIT  = 900_000;
   localparam int  DRAIN_CYCLES = 120;
   localparam int  HOLD_AT_ITEM = 500;
   localparam int  HOLD_CYCLES  = 300;
   localparam int  SHOW_LIMIT   = 10;
   localparam int  ROW_COUNT    = 26;
   localparam logic [OP_W-1:0]   OP_NONE = 2'd3;
   localparam logic [CHAR_W-1:0] NO_CHAR = 8'h00;

   typedef logic signed [63:0] wide_type;

   // one result word as the block returns it
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] result_value;
      logic                     done_res;
   } result_word_type;

   // one directed token, with its result typed in where it is obvious
   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
      logic [CHAR_W-1:0]        opchar;
      logic                     typed;
      logic [STATUS_W-1:0]      exp_status;
      logic signed [DATA_W-1:0] exp_value;
      logic                     exp_done;
   } token_row_type;

   logic clock = 1'b0;
   logic reset;

   pse_req_if req_bus ();
   pse_rsp_if rsp_bus ();

   postfix_stack_evaluator #(
      .STACK_DEPTH (STACK_DEPTH_DEF),
      .FRAC_BITS   (FRAC_BITS_DEF)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #6 clock = ~clock;

   // shadow copy of the operand stack
   logic signed [DATA_W-1:0] shadow_stack [STACK_DEPTH_DEF];
   int                       shadow_depth = 0;

   result_word_type awaited_words [$];
   int  items_sent     = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  steady         = 1'b0;

   token_row_type directed_rows [ROW_COUNT] = '{
      '{OP_END,   32'sd0,        NO_CHAR,  1'b1, ST_UNDER,   32'sd0,  1'b1},
      '{OP_APPLY, 32'sd0,        CHAR_ADD, 1'b1, ST_UNDER,   32'sd0,  1'b1},
      '{OP_PUSH,  SAT_MAX,       NO_CHAR,  1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_PUSH,  32'sd1,        NO_CHAR,  1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_APPLY, 32'sd0,        CHAR_ADD, 1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_END,   32'sd0,        NO_CHAR,  1'b1, ST_OK,      SAT_MAX, 1'b1},
      '{OP_PUSH,  SAT_MIN,       NO_CHAR,  1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_PUSH,  32'sh0001_0000, NO_CHAR, 1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_APPLY, 32'sd0,        CHAR_SUB, 1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_END,   32'sd0,        NO_CHAR,  1'b1, ST_OK,      SAT_MIN, 1'b1},
      '{OP_PUSH,  32'sh0003_0000, NO_CHAR, 1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_PUSH,  32'sd0,        NO_CHAR,  1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_APPLY, 32'sd0,        CHAR_DIV, 1'b1, ST_DIVZERO, 32'sd0,  1'b1},
      '{OP_PUSH,  32'shFFFD_8000, NO_CHAR, 1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_PUSH,  32'sh0001_8000, NO_CHAR, 1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_APPLY, 32'sd0,        CHAR_MUL, 1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_PUSH,  32'sh0002_0000, NO_CHAR, 1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_APPLY, 32'sd0,        CHAR_DIV, 1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_END,   32'sd0,        NO_CHAR,  1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_PUSH,  32'sd7,        NO_CHAR,  1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_PUSH,  -32'sd1,       NO_CHAR,  1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_APPLY, 32'sd0,        8'hFF,    1'b1, ST_BADOP,   32'sd0,  1'b1},
      '{OP_PUSH,  32'sd1,        NO_CHAR,  1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_PUSH,  32'sd2,        NO_CHAR,  1'b0, ST_OK,      32'sd0,  1'b0},
      '{OP_END,   32'sd0,        NO_CHAR,  1'b1, ST_LEFT,    32'sd0,  1'b1},
      '{OP_NONE,  32'shA5A5_A5A5, 8'h5A,   1'b1, ST_OK,      32'sd0,  1'b0}
   };

   // saturate a wide value to the 32-bit range
   function automatic logic signed [DATA_W-1:0] clip32(input wide_type x);
      if (x > wide_type'(SAT_MAX))
         return SAT_MAX;
      if (x < wide_type'(SAT_MIN))
         return SAT_MIN;
      return x[DATA_W-1:0];
   endfunction

   // shadow evaluator: one token in, one result word out
   function automatic result_word_type evaluate_token(input logic [OP_W-1:0] op,
                                                      input logic signed [DATA_W-1:0] value,
                                                      input logic [CHAR_W-1:0] opchar);
      result_word_type word;
      wide_type        lhs, rhs;
      logic signed [DATA_W-1:0] outcome;
      word = '{ST_OK, 32'sd0, 1'b0};
      case (op)
         OP_PUSH: begin
            if (shadow_depth >= STACK_DEPTH_DEF) begin
               shadow_depth = 0;
               word = '{ST_OVER, 32'sd0, 1'b1};
            end else begin
               shadow_stack[shadow_depth] = value;
               shadow_depth++;
            end
         end
         OP_APPLY: begin
            if (shadow_depth < 2) begin
               shadow_depth = 0;
               word = '{ST_UNDER, 32'sd0, 1'b1};
            end else begin
               rhs = shadow_stack[shadow_depth-1];
               lhs = shadow_stack[shadow_depth-2];
               shadow_depth -= 2;
               outcome = '0;
               case (opchar)
                  CHAR_ADD: outcome = clip32(lhs + rhs);
                  CHAR_SUB: outcome = clip32(lhs - rhs);
                  CHAR_MUL: outcome = clip32((lhs * rhs) >>> FRAC_BITS_DEF);
                  CHAR_DIV: begin
                     if (rhs == 0)
                        word = '{ST_DIVZERO, 32'sd0, 1'b1};
                     else
                        outcome = clip32((lhs <<< FRAC_BITS_DEF) / rhs);
                  end
                  default: word = '{ST_BADOP, 32'sd0, 1'b1};
               endcase
               if (word.done_res) begin
                  shadow_depth = 0;
               end else begin
                  shadow_stack[shadow_depth] = outcome;
                  shadow_depth++;
               end
            end
         end
         OP_END: begin
            if (shadow_depth == 0)
               word = '{ST_UNDER, 32'sd0, 1'b1};
            else if (shadow_depth > 1)
               word = '{ST_LEFT, 32'sd0, 1'b1};
            else
               word = '{ST_OK, shadow_stack[0], 1'b1};
            shadow_depth = 0;
         end
         default: ;
      endcase
      return word;
   endfunction

   // offer one token word, wait for acceptance, then queue its result
   task automatic send_token(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                             input logic [CHAR_W-1:0] opchar, input bit typed,
                             input result_word_type typed_word);
      result_word_type predicted;
      int              gap;
      if (!steady && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.op            <= op;
      req_bus.value         <= value;
      req_bus.operator_char <= opchar;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = evaluate_token(op, value, opchar);
      awaited_words.push_back(typed ? typed_word : predicted);
      if (op != OP_NONE)
         items_sent++;
   endtask

   // operand values, biased toward the extremes and zero
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return 32'sd0;
         3: return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
         4, 5: return $signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
         default: return $urandom;
      endcase
   endfunction

   // mostly the four operators, now and then any character
   function automatic logic [CHAR_W-1:0] pick_operator();
      case ($urandom_range(0, 19))
         0: return CHAR_W'($urandom_range(0, 255));
         1, 2, 3, 4, 5: return CHAR_ADD;
         6, 7, 8, 9: return CHAR_SUB;
         10, 11, 12, 13, 14: return CHAR_MUL;
         default: return CHAR_DIV;
      endcase
   endfunction

   // well-formed expression over n operands; a flaw adds an operand or an operator
   task automatic send_expression(input int n, input int flaw);
      int depth, left;
      depth = 0;
      left  = n;
      while (left > 0 || depth > 1) begin
         if (left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
            send_token(OP_PUSH, pick_value(), CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
            depth++;
            left--;
         end else begin
            send_token(OP_APPLY, $urandom, pick_operator(), 1'b0, '0);
            depth--;
         end
      end
      if (flaw == 1)
         send_token(OP_PUSH, pick_value(), NO_CHAR, 1'b0, '0);
      else if (flaw == 2)
         send_token(OP_APPLY, $urandom, pick_operator(), 1'b0, '0);
      send_token(OP_END, $urandom, CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   // all pushes first, so an n near the depth runs the stack up to full or past it
   task automatic send_tall(input int n);
      repeat (n) send_token(OP_PUSH, pick_value(), NO_CHAR, 1'b0, '0);
      repeat (n - 1) send_token(OP_APPLY, 32'sd0, pick_operator(), 1'b0, '0);
      send_token(OP_END, 32'sd0, NO_CHAR, 1'b0, '0);
   endtask

   // compare one accepted result word with the oldest expectation
   task automatic check_result();
      result_word_type want;
      if (awaited_words.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= SHOW_LIMIT)
            $display("unexpected result word: status %0d value %0d done %0b",
                     rsp_bus.status, rsp_bus.result_value, rsp_bus.done_res);
      end else begin
         want = awaited_words.pop_front();
         if (rsp_bus.status !== want.status || rsp_bus.result_value !== want.result_value ||
             rsp_bus.done_res !== want.done_res) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
               $display("mismatch: expected status %0d value %0d done %0b, got %0d %0d %0b",
                        want.status, want.result_value, want.done_res,
                        rsp_bus.status, rsp_bus.result_value, rsp_bus.done_res);
         end
      end
   endtask

   // receiver: random stall bursts, one long hold, checks at the rising edge
   initial begin : result_sink
      int  stall_left;
      bit  held;
      stall_left    = 0;
      held          = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && items_sent >= HOLD_AT_ITEM) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !steady && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            check_result();
      end
   end

   // cycle limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // reset, directed table, random expressions, drain
   initial begin : token_source
      int pick;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.op            = OP_PUSH;
      req_bus.value         = '0;
      req_bus.operator_char = NO_CHAR;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i])
         send_token(directed_rows[i].op, directed_rows[i].value, directed_rows[i].opchar,
                    directed_rows[i].typed,
                    '{directed_rows[i].exp_status, directed_rows[i].exp_value,
                      directed_rows[i].exp_done});

      // random part, mostly well-formed expressions
      while (items_sent < ITEM_TARGET) begin
         steady = (items_sent >= ITEM_TARGET - STEADY_TAIL);
         pick   = $urandom_range(0, 59);
         if (pick < 45) begin
            send_expression($urandom_range(1, 8), 0);
         end else if (pick < 52) begin
            send_expression($urandom_range(1, 6), $urandom_range(1, 2));
         end else if (pick == 52) begin
            send_tall($urandom_range(62, 66));
         end else begin
            repeat ($urandom_range(1, 4))
               send_token(OP_W'($urandom_range(0, 3)), $urandom,
                          $urandom_range(0, 1) ? pick_operator()
                                               : CHAR_W'($urandom_range(0, 255)),
                          1'b0, '0);
         end
      end
      steady = 1'b1;
      @(negedge clock);
      req_bus.valid <= 1'b0;

      // wait for every result word, then a quiet stretch
      while (awaited_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
sv/pse_pkg.sv
sv/pse_if.sv
sv/pse_cell.sv
sv/pse_alu.sv
sv/postfix_stack_evaluator.sv
sv/pse_checker.sv
dv/postfix_stack_evaluator_test.sv
